// File: rtl/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled in reset.
`define ASSERT_IMPLY(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) \
    else $error(msg);

// Next-cycle implication, disabled in reset.
`define ASSERT_NEXT(label, clk, rst, a, b, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) \
    else $error(msg);

`endif

// File: rtl/lfl_pkg.sv
// ----------------------------------------------------------------------------
// lfl_pkg
// Types, codes and defaults of the linked free-list record store.
// ----------------------------------------------------------------------------
package lfl_pkg;

  localparam int NODES_DEF    = 32;
  localparam int KEY_BITS_DEF = 16;

  localparam int FUNC_W  = 3;
  localparam int ADDR_W  = 5;
  localparam int KEY_W   = 16;
  localparam int VAL_W   = 32;
  localparam int COUNT_W = 6;
  localparam int STAT_W  = 2;

  localparam logic [FUNC_W-1:0] FN_ALLOC = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FREE  = 3'd1;
  localparam logic [FUNC_W-1:0] FN_PUT   = 3'd2;
  localparam logic [FUNC_W-1:0] FN_GET   = 3'd3;
  localparam logic [FUNC_W-1:0] FN_QUERY = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_NOFREE = 2'd1;
  localparam logic [STAT_W-1:0] ST_MISS   = 2'd2;

  typedef struct packed {
    logic [FUNC_W-1:0]       func;
    logic [ADDR_W-1:0]       address;
    logic [KEY_W-1:0]        key;
    logic signed [VAL_W-1:0] value;
    logic [COUNT_W-1:0]      count;
    logic                    last;
  } in_t;

  typedef struct packed {
    logic [STAT_W-1:0]       status;
    logic [ADDR_W-1:0]       head;
    logic signed [VAL_W-1:0] read_value;
    logic                    is_free;
    logic [COUNT_W-1:0]      free_count;
  } out_t;

  typedef enum logic [1:0] {
    RD_ADDR,
    RD_FREE_HEAD,
    RD_LINKQ
  } rd_sel_t;

  typedef struct packed {
    logic    init_wr;
    logic    load_item;
    rd_sel_t rd_sel;
    logic    alloc_check;
    logic    alloc_take;
    logic    alloc_link;
    logic    alloc_end;
    logic    free_start;
    logic    free_step;
    logic    free_commit;
    logic    find_start;
    logic    find_step;
    logic    find_hit;
    logic    find_miss;
    logic    query_start;
    logic    query_step;
    logic    query_hit;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic              init_done;
    logic              init_last;
    logic [FUNC_W-1:0] func;
    logic              addr_ok;
    logic              chk_refuse;
    logic              tail_null;
    logic              lq_null;
    logic              walk_more;
    logic              key_hit;
    logic              find_more;
    logic              qh_null;
    logic              qh_hit;
    logic              q_more;
    logic              q_hit;
    logic              out_free;
  } stat_t;

endpackage

// File: rtl/lfl_dpath.sv
// ----------------------------------------------------------------------------
// lfl_dpath
// Node memories, free-list and record registers, walk counters, result
// and output registers.
// ----------------------------------------------------------------------------
module lfl_dpath #(
  parameter int NODES    = lfl_pkg::NODES_DEF,
  parameter int KEY_BITS = lfl_pkg::KEY_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  lfl_pkg::in_t  in_data,
  input  lfl_pkg::cmd_t cmd,
  input  logic          out_ready,
  output logic          out_valid,
  output lfl_pkg::out_t out_data,
  output lfl_pkg::stat_t stat
);
  import lfl_pkg::*;

  localparam int IW = (NODES > 1) ? $clog2(NODES) : 1;
  localparam int LW = $clog2(NODES + 1);
  localparam int CW = (LW > ADDR_W) ? LW : ADDR_W;
  localparam int TW = (LW > COUNT_W) ? LW : COUNT_W;
  localparam int NW = LW + 2;
  localparam logic [LW-1:0] NULL_L = LW'(NODES);

  logic [KEY_BITS-1:0] node_key   [NODES];
  logic [VAL_W-1:0]    node_value [NODES];
  logic [LW-1:0]       node_link  [NODES];

  in_t                 item;
  logic [LW-1:0]       free_head;
  logic [LW-1:0]       free_total;
  logic                record_open;
  logic                record_refused;
  logic [IW-1:0]       record_start;
  logic [LW-1:0]       record_tail;
  logic [IW-1:0]       init_idx;
  logic                init_done;
  logic [IW-1:0]       cur;
  logic [IW-1:0]       x;
  logic [LW:0]         walk_cnt;
  logic [LW-1:0]       step;
  logic [KEY_BITS-1:0] key_q;
  logic [LW-1:0]       link_q;
  logic [VAL_W-1:0]    value_q;
  logic [STAT_W-1:0]   res_status;
  logic [ADDR_W-1:0]   res_head;
  logic [VAL_W-1:0]    res_rd;
  logic                res_isf;

  logic [KEY_BITS-1:0] kk;
  logic [CW-1:0]       addr_c;
  logic [IW-1:0]       addr_idx;
  logic [IW-1:0]       rd_idx;
  logic                fh_null;
  logic [TW-1:0]       total_t;
  logic [CW-1:0]       start_c;
  logic [NW-1:0]       sum;
  logic [LW-1:0]       total_add;
  logic                refuse_now;
  logic [LW:0]         step_inc;

  always_comb begin
    kk = '0;
    for (int b = 0; b < KEY_BITS; b++) begin
      if (b < KEY_W) kk[b] = item.key[b];
    end
  end

  assign addr_c   = CW'(item.address);
  assign addr_idx = addr_c[IW-1:0];
  assign fh_null  = (free_head >= NULL_L);
  assign total_t  = TW'(free_total);
  assign start_c  = CW'(record_start);
  assign sum      = NW'(free_total) + NW'(walk_cnt);
  assign total_add = (sum > NW'(NODES)) ? NULL_L : sum[LW-1:0];
  assign step_inc = (LW+1)'(step) + (LW+1)'(1);
  assign refuse_now = (record_open ? record_refused
                                   : (TW'(item.count) > total_t)) | fh_null;

  always_comb begin
    case (cmd.rd_sel)
      RD_ADDR:      rd_idx = addr_idx;
      RD_FREE_HEAD: rd_idx = free_head[IW-1:0];
      RD_LINKQ:     rd_idx = link_q[IW-1:0];
      default:      rd_idx = addr_idx;
    endcase
  end

  always_comb begin
    stat.init_done  = init_done;
    stat.init_last  = (init_idx == IW'(NODES - 1));
    stat.func       = item.func;
    stat.addr_ok    = (addr_c < CW'(NODES));
    stat.chk_refuse = refuse_now;
    stat.tail_null  = (record_tail >= NULL_L);
    stat.lq_null    = (link_q >= NULL_L);
    stat.walk_more  = (step < NULL_L);
    stat.key_hit    = (key_q == kk);
    stat.find_more  = (step_inc < (LW+1)'(NODES)) && (link_q < NULL_L);
    stat.qh_null    = fh_null;
    stat.qh_hit     = (CW'(free_head) == addr_c);
    stat.q_more     = (step < NULL_L) && (link_q < NULL_L);
    stat.q_hit      = (CW'(link_q) == addr_c);
    stat.out_free   = !out_valid || out_ready;
  end

  // Node memories: one registered read port, one write port each.
  always_ff @(posedge clk) begin
    key_q   <= node_key[rd_idx];
    link_q  <= node_link[rd_idx];
    value_q <= node_value[rd_idx];
    if (cmd.init_wr) begin
      node_link[init_idx] <= LW'(init_idx) + LW'(1);
    end else if (cmd.alloc_take) begin
      node_link[free_head[IW-1:0]] <= NULL_L;
    end else if (cmd.alloc_link) begin
      node_link[record_tail[IW-1:0]] <= LW'(cur);
    end else if (cmd.free_commit) begin
      node_link[x] <= free_head;
    end
    if (cmd.alloc_take) node_key[free_head[IW-1:0]] <= kk;
    if (cmd.find_hit && item.func == FN_PUT) node_value[x] <= item.value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      init_idx       <= '0;
      init_done      <= 1'b0;
      free_head      <= '0;
      free_total     <= NULL_L;
      record_open    <= 1'b0;
      record_refused <= 1'b0;
      record_start   <= '0;
      record_tail    <= NULL_L;
      out_valid      <= 1'b0;
    end else begin
      if (cmd.init_wr) begin
        init_idx <= init_idx + IW'(1);
        if (stat.init_last) init_done <= 1'b1;
      end
      if (cmd.alloc_check) begin
        record_open    <= 1'b1;
        record_refused <= refuse_now;
        if (!record_open) record_tail <= NULL_L;
      end
      if (cmd.alloc_take) begin
        free_head <= link_q;
        if (record_tail >= NULL_L) begin
          record_start <= free_head[IW-1:0];
          record_tail  <= free_head;
        end
        if (free_total != '0) free_total <= free_total - LW'(1);
      end
      if (cmd.alloc_link) record_tail <= LW'(cur);
      if (cmd.alloc_end && item.last) begin
        record_open    <= 1'b0;
        record_refused <= 1'b0;
        record_tail    <= NULL_L;
      end
      if (cmd.free_commit) begin
        free_head  <= LW'(addr_idx);
        free_total <= total_add;
      end
      if (cmd.out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item       <= in_data;
      res_status <= ST_OK;
      res_head   <= '0;
      res_rd     <= '0;
      res_isf    <= 1'b0;
    end
    if (cmd.alloc_take) cur <= free_head[IW-1:0];
    if (cmd.alloc_end) begin
      res_status <= record_refused ? ST_NOFREE : ST_OK;
      if (item.last && !record_refused) res_head <= start_c[ADDR_W-1:0];
    end
    if (cmd.free_start) begin
      x        <= addr_idx;
      walk_cnt <= (LW+1)'(1);
      step     <= '0;
    end
    if (cmd.free_step) begin
      x        <= link_q[IW-1:0];
      walk_cnt <= walk_cnt + (LW+1)'(1);
      step     <= step + LW'(1);
    end
    if (cmd.find_start) begin
      x    <= addr_idx;
      step <= '0;
    end
    if (cmd.find_step) begin
      x    <= link_q[IW-1:0];
      step <= step + LW'(1);
    end
    if (cmd.find_hit && item.func == FN_GET) res_rd <= value_q;
    if (cmd.find_miss && item.func == FN_GET) res_status <= ST_MISS;
    if (cmd.query_start) step <= LW'(1);
    if (cmd.query_step) step <= step + LW'(1);
    if (cmd.query_hit) res_isf <= 1'b1;
    if (cmd.out_load) begin
      out_data.status     <= res_status;
      out_data.head       <= res_head;
      out_data.read_value <= res_rd;
      out_data.is_free    <= res_isf;
      out_data.free_count <= total_t[COUNT_W-1:0];
    end
  end

endmodule

// File: rtl/lfl_ctrl.sv
// ----------------------------------------------------------------------------
// lfl_ctrl
// Sequencer: clearing pass, dispatch by function, chain walks, result hand-off.
// ----------------------------------------------------------------------------
module lfl_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  lfl_pkg::stat_t stat,
  output lfl_pkg::cmd_t  cmd
);
  import lfl_pkg::*;

  typedef enum logic [3:0] {
    S_INIT, S_IDLE, S_DISP, S_A_TAKE, S_A_LINK, S_A_END,
    S_F_WALK, S_S_WALK, S_Q_WALK, S_DONE
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) state <= S_INIT;
    else state <= state_next;
  end

  always_comb begin
    cmd        = '0;
    cmd.rd_sel = RD_LINKQ;
    state_next = state;
    unique case (state)
      S_INIT: begin
        cmd.init_wr = 1'b1;
        if (stat.init_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item = 1'b1;
          state_next    = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.func) inside
          FN_ALLOC: begin
            cmd.alloc_check = 1'b1;
            cmd.rd_sel      = RD_FREE_HEAD;
            state_next      = stat.chk_refuse ? S_A_END : S_A_TAKE;
          end
          FN_FREE: begin
            cmd.rd_sel = RD_ADDR;
            if (stat.addr_ok) begin
              cmd.free_start = 1'b1;
              state_next     = S_F_WALK;
            end else begin
              state_next = S_DONE;
            end
          end
          FN_PUT, FN_GET: begin
            cmd.rd_sel = RD_ADDR;
            if (stat.addr_ok) begin
              cmd.find_start = 1'b1;
              state_next     = S_S_WALK;
            end else begin
              cmd.find_miss = 1'b1;
              state_next    = S_DONE;
            end
          end
          FN_QUERY: begin
            cmd.rd_sel      = RD_FREE_HEAD;
            cmd.query_start = 1'b1;
            if (stat.qh_null) begin
              state_next = S_DONE;
            end else if (stat.qh_hit) begin
              cmd.query_hit = 1'b1;
              state_next    = S_DONE;
            end else begin
              state_next = S_Q_WALK;
            end
          end
          default: state_next = S_DONE;
        endcase
      end
      S_A_TAKE: begin
        cmd.alloc_take = 1'b1;
        state_next     = stat.tail_null ? S_A_END : S_A_LINK;
      end
      S_A_LINK: begin
        cmd.alloc_link = 1'b1;
        state_next     = S_A_END;
      end
      S_A_END: begin
        cmd.alloc_end = 1'b1;
        state_next    = S_DONE;
      end
      S_F_WALK: begin
        if (stat.lq_null) begin
          cmd.free_commit = 1'b1;
          state_next      = S_DONE;
        end else if (stat.walk_more) begin
          cmd.free_step = 1'b1;
        end else begin
          state_next = S_DONE;  // cyclic chain: drop the free
        end
      end
      S_S_WALK: begin
        if (stat.key_hit) begin
          cmd.find_hit = 1'b1;
          state_next   = S_DONE;
        end else if (stat.find_more) begin
          cmd.find_step = 1'b1;
        end else begin
          cmd.find_miss = 1'b1;
          state_next    = S_DONE;
        end
      end
      S_Q_WALK: begin
        if (stat.q_more) begin
          if (stat.q_hit) begin
            cmd.query_hit = 1'b1;
            state_next    = S_DONE;
          end else begin
            cmd.query_step = 1'b1;
          end
        end else begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

// File: rtl/linked_free_list_record_store.sv
// Sequence: alloc goes from dispatch through take, link and end (no link for a
// record's first node, straight to end when refused); free, put, get and query
// walk their chain link by link; unused codes go straight to the result.
// Throughput: one item at a time; the next transfer is taken once the result
// is in the output register, which may still wait for out_ready.
// Reset: synchronous; a clearing pass rebuilds the free list before the first transfer is taken.
// ----------------------------------------------------------------------------
// linked_free_list_record_store
// Node store with a linked free list: record allocation, chain free, keyed
// put and get, free-list query.
// ----------------------------------------------------------------------------
module linked_free_list_record_store #(
  parameter int NODES    = lfl_pkg::NODES_DEF,
  parameter int KEY_BITS = lfl_pkg::KEY_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  lfl_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output lfl_pkg::out_t out_data
);
  import lfl_pkg::*;
  `include "assert_macros.svh"

  cmd_t  cmd;
  stat_t stat;

  lfl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lfl_dpath #(
    .NODES    (NODES),
    .KEY_BITS (KEY_BITS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cmd       (cmd),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

  `ASSERT_IMPLY(a_ready_after_init, clk, rst, in_ready, stat.init_done, "transfer before clear")
  `ASSERT_IMPLY(a_head_ok, clk, rst, out_valid && out_data.head != '0, out_data.status == ST_OK, "head on failed alloc")
  `ASSERT_NEXT(a_load_valid, clk, rst, cmd.out_load, out_valid, "result not presented")

endmodule

// File: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives the linked free-list record store with random records, puts, gets,
// frees and queries under random idle and stall bursts on both channels.
// Each result is compared field by field with a prediction made on every
// input transfer.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import lfl_pkg::*;

  localparam int N       = NODES_DEF;
  localparam int NUM_ITEMS = 2000;
  localparam int WDOG_LIMIT = 4000;

  class store_scoreboard;
    logic [KEY_W-1:0] node_key[N];
    logic [VAL_W-1:0] node_val[N];
    int               node_next[N];
    bit               key_set[N];
    bit               val_set[N];
    int               free_head;
    int               free_total;
    bit               rec_open;
    bit               rec_refused;
    int               rec_start;
    int               rec_tail;
    out_t             pending[$];
    int               errors;

    function new();
      for (int i = 0; i < N; i++) begin
        node_key[i]  = '0;
        node_val[i]  = '0;
        node_next[i] = i + 1;
        key_set[i]   = 0;
        val_set[i]   = 0;
      end
      free_head   = 0;
      free_total  = N;
      rec_open    = 0;
      rec_refused = 0;
      rec_start   = 0;
      rec_tail    = N;
      errors      = 0;
    endfunction

    function int find_node(int start, logic [KEY_W-1:0] k);
      int z;
      z = start;
      for (int i = 0; i < N && z < N; i++) begin
        if (node_key[z] == k) return z;
        z = node_next[z];
      end
      return -1;
    endfunction

    // A put or get must never compare or return a node word never written.
    function bit is_safe(in_t x);
      int z;
      if (x.func != FN_PUT && x.func != FN_GET) return 1;
      z = x.address;
      for (int i = 0; i < N && z < N; i++) begin
        if (!key_set[z]) return 0;
        if (node_key[z] == x.key) return (x.func == FN_PUT) || val_set[z];
        z = node_next[z];
      end
      return 1;
    endfunction

    function void note_input(in_t x);
      out_t o;
      int   n, z, c, t;
      o = '0;
      case (x.func)
        FN_ALLOC: begin
          if (!rec_open) begin
            rec_open    = 1;
            rec_refused = x.count > free_total;
            rec_tail    = N;
          end
          if (!rec_refused && free_head >= N) rec_refused = 1;
          if (rec_refused) begin
            o.status = ST_NOFREE;
          end else begin
            n = free_head;
            free_head = node_next[n];
            node_next[n] = N;
            node_key[n] = x.key;
            key_set[n] = 1;
            if (rec_tail < N) node_next[rec_tail] = n;
            else rec_start = n;
            rec_tail = n;
            if (free_total > 0) free_total--;
          end
          if (x.last) begin
            if (!rec_refused) o.head = ADDR_W'(rec_start);
            rec_open    = 0;
            rec_refused = 0;
            rec_tail    = N;
          end
        end
        FN_FREE: begin
          t = x.address;
          c = 1;
          for (int i = 0; i < N && node_next[t] < N; i++) begin
            t = node_next[t];
            c++;
          end
          if (node_next[t] >= N) begin
            node_next[t] = free_head;
            free_head = x.address;
            free_total += c;
            if (free_total > N) free_total = N;
          end
        end
        FN_PUT: begin
          z = find_node(x.address, x.key);
          if (z >= 0) begin
            node_val[z] = x.value;
            val_set[z] = 1;
          end
        end
        FN_GET: begin
          z = find_node(x.address, x.key);
          if (z >= 0) o.read_value = node_val[z];
          else o.status = ST_MISS;
        end
        FN_QUERY: begin
          t = free_head;
          for (int i = 0; i < N && t < N; i++) begin
            if (t == x.address) begin
              o.is_free = 1;
              break;
            end
            t = node_next[t];
          end
        end
        default: ;
      endcase
      o.free_count = COUNT_W'(free_total);
      pending.push_back(o);
    endfunction

    function void check_result(out_t g);
      out_t e;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %p", $time, g);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (g.status !== e.status) begin
        $display("%0t: status expected %0d actual %0d", $time, e.status, g.status);
        errors++;
      end
      if (g.head !== e.head) begin
        $display("%0t: head expected %0d actual %0d", $time, e.head, g.head);
        errors++;
      end
      if (g.read_value !== e.read_value) begin
        $display("%0t: read_value expected %h actual %h", $time, e.read_value,
                 g.read_value);
        errors++;
      end
      if (g.is_free !== e.is_free) begin
        $display("%0t: is_free expected %0d actual %0d", $time, e.is_free, g.is_free);
        errors++;
      end
      if (g.free_count !== e.free_count) begin
        $display("%0t: free_count expected %0d actual %0d", $time, e.free_count,
                 g.free_count);
        errors++;
      end
    endfunction
  endclass

  typedef struct {
    int               head;
    int               len;
    logic [KEY_W-1:0] keys[12];
  } record_t;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  store_scoreboard sb;
  record_t         live[$];
  bit              bursts_on;
  int              accepted;
  int              quiet_cycles;
  int              stall_left;

  linked_free_list_record_store u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Result side: check at the edge, then pick the next ready level.
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      sb.check_result(out_data);
    end
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 0;
    end else if (bursts_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      out_ready  <= 0;
    end else begin
      out_ready <= 1;
    end
  end

  // Watchdog on cycles with no transfer on either side.
  always @(posedge clk) begin
    if (!rst && !(in_valid && in_ready) && !(out_valid && out_ready)) begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end else if (!rst) begin
      quiet_cycles <= 0;
    end
  end

  task automatic send_item(in_t x);
    if (bursts_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1;
    in_data  <= x;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_input(x);
    accepted++;
  endtask

  function automatic in_t make_item(int f, int addr, logic [31:0] k,
                                    logic [31:0] v, int cnt, int lst);
    in_t x;
    x.func    = FUNC_W'(f);
    x.address = ADDR_W'(addr);
    x.key     = k[KEY_W-1:0];
    x.value   = v;
    x.count   = COUNT_W'(cnt);
    x.last    = lst[0];
    return x;
  endfunction

  // Put or get if it stays within written nodes, else query the same node.
  task automatic send_guarded(in_t x);
    if (!sb.is_safe(x)) x.func = FN_QUERY;
    send_item(x);
  endtask

  task automatic alloc_record(int len, int cnt);
    record_t r;
    in_t     x;
    out_t    e;
    r.len = len;
    for (int i = 0; i < len; i++) begin
      r.keys[i] = KEY_W'($urandom);
      x = make_item(FN_ALLOC, $urandom, r.keys[i], $urandom, cnt, i == len - 1);
      send_item(x);
    end
    e = sb.pending[$];
    if (e.status == ST_OK) begin
      r.head = e.head;
      live.push_back(r);
    end
  endtask

  task automatic random_op();
    int      sel, idx;
    record_t r;
    sel = $urandom_range(0, 99);
    if (live.size() > 0) begin
      idx = $urandom_range(0, live.size() - 1);
      r = live[idx];
    end
    if (sel < 28 || live.size() == 0) begin
      int len;
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 6);
      alloc_record(len, ($urandom_range(0, 5) == 0) ? $urandom_range(0, 63) : len);
    end else if (sel < 52) begin
      send_guarded(make_item(FN_PUT, r.head, r.keys[$urandom_range(0, r.len - 1)],
                             $urandom, $urandom, $urandom));
    end else if (sel < 74) begin
      send_guarded(make_item(FN_GET, r.head,
                             ($urandom_range(0, 5) == 0) ? $urandom :
                               r.keys[$urandom_range(0, r.len - 1)],
                             $urandom, $urandom, $urandom));
    end else if (sel < 83) begin
      send_item(make_item(FN_FREE, r.head, $urandom, $urandom, $urandom, $urandom));
      live.delete(idx);
    end else if (sel < 85) begin
      send_item(make_item(FN_FREE, $urandom, $urandom, $urandom, $urandom, $urandom));
    end else if (sel < 93) begin
      send_item(make_item(FN_QUERY, $urandom, $urandom, $urandom, $urandom, $urandom));
    end else if (sel < 97) begin
      send_guarded(make_item($urandom_range(FN_PUT, FN_GET), $urandom, $urandom,
                             $urandom, $urandom, $urandom));
    end else begin
      send_item(make_item($urandom_range(5, 7), $urandom, $urandom, $urandom,
                          $urandom, $urandom));
    end
  endtask

  initial begin
    sb           = new();
    bursts_on    = 1;
    accepted     = 0;
    quiet_cycles = 0;
    stall_left   = 0;
    rst          = 1;
    in_valid     = 0;
    in_data      = '0;
    out_ready    = 0;
    repeat (8) @(posedge clk);
    rst <= 0;

    // Three-node record with extreme keys, then put/get at value extremes.
    send_item(make_item(FN_ALLOC, 0, 16'h0000, 0, 3, 0));
    send_item(make_item(FN_ALLOC, 31, 16'hFFFF, 0, 0, 0));
    send_item(make_item(FN_ALLOC, 0, 16'h1234, 0, 63, 1));
    send_item(make_item(FN_PUT, 0, 16'h0000, 32'h7FFF_FFFF, 0, 0));
    send_item(make_item(FN_PUT, 0, 16'hFFFF, 32'h8000_0000, 0, 0));
    send_item(make_item(FN_PUT, 0, 16'h1234, 32'hFFFF_FFFF, 0, 0));
    send_item(make_item(FN_PUT, 0, 16'h5555, 32'h1, 0, 0));
    send_item(make_item(FN_GET, 0, 16'h0000, 0, 0, 0));
    send_item(make_item(FN_GET, 0, 16'hFFFF, 0, 0, 0));
    send_item(make_item(FN_GET, 0, 16'h1234, 0, 0, 0));
    send_item(make_item(FN_GET, 0, 16'hAAAA, 0, 0, 0));
    send_item(make_item(FN_QUERY, 0, 0, 0, 0, 0));
    send_item(make_item(FN_QUERY, 31, 0, 0, 0, 0));
    // Count zero, then a refused record, then unused codes.
    send_item(make_item(FN_ALLOC, 0, 16'h00FF, 0, 0, 1));
    send_item(make_item(FN_ALLOC, 0, 16'h0F0F, 0, 63, 0));
    send_item(make_item(FN_ALLOC, 0, 16'hF0F0, 0, 33, 1));
    send_item(make_item(5, 31, 16'hFFFF, 32'hFFFF_FFFF, 63, 1));
    send_item(make_item(6, 0, 0, 0, 0, 0));
    send_item(make_item(7, 0, 0, 0, 0, 0));
    // Free the first record, query it, then free a free-list node.
    send_item(make_item(FN_FREE, 0, 0, 0, 0, 0));
    send_item(make_item(FN_QUERY, 0, 0, 0, 0, 0));
    send_item(make_item(FN_FREE, 31, 0, 0, 0, 0));
    send_item(make_item(FN_QUERY, 31, 0, 0, 0, 0));

    while (accepted < NUM_ITEMS) begin
      if (accepted > NUM_ITEMS * 17 / 20) bursts_on = 0;
      random_op();
    end
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (N + 10) @(posedge clk);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/lfl_pkg.sv
rtl/lfl_dpath.sv
rtl/lfl_ctrl.sv
rtl/linked_free_list_record_store.sv
tb/testbench.sv
